FILE: rtl/sstf_pkg.sv
// Shared types and codes for the SSTF seek scheduler.
`default_nettype none
package sstf_pkg;

  localparam int TRK_W = 16;
  localparam int TOT_W = 32;
  localparam int CNT_W = 16;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef logic [TRK_W-1:0] trk_t;

  typedef struct packed {
    trk_t gap;
    logic take;
  } gap_res_t;

endpackage
`default_nettype wire

FILE: rtl/sstf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/sstf_gap_unit.sv
// Shared distance unit: absolute track gap and compare against the best so far.
`default_nettype none
module sstf_gap_unit (
  input  wire sstf_pkg::trk_t   trk,
  input  wire sstf_pkg::trk_t   head,
  input  wire sstf_pkg::trk_t   best_gap,
  input  wire logic             first,
  output sstf_pkg::gap_res_t    res
);

  sstf_pkg::trk_t gap;

  always_comb begin
    gap      = (trk >= head) ? (trk - head) : (head - trk);
    res.gap  = gap;
    res.take = first || (gap < best_gap);
  end

endmodule
`default_nettype wire

FILE: rtl/sstf_seek_scheduler.sv
// Top level of the shortest-seek-time-first disk arm scheduler.
//
//  channel | dir | handshake           | word
//  in_     | in  | in_tvalid/in_tready | tuser: operation; tdata: track
//  out_    | out | out_tvalid/out_tready| tuser: found; tdata: track, seek, total, count
//  cfg_    | in  | cfg_valid/cfg_ready | data: start_track
//
// A push is handled in S_IDLE. A serve scans the table in S_SCAN, then emits in S_EMIT:
// the scan reads one table entry per cycle through the single RAM read port and the
// shared gap unit. A serve on an empty table goes straight to S_EMIT. in_tready is low
// while a serve runs, including while its word waits for the output register to free up.
// Reset empties the table, clears head and totals and drops any pending output word.
`default_nettype none
module sstf_seek_scheduler #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] track
  input  wire logic [0:0]  in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [15:0] served_track, [31:16] seek_distance,
                                       // [63:32] total_distance, [79:64] served_count
  output logic [0:0]       out_tuser,  // [0] found
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // [15:0] start_track
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = sstf_pkg::TOT_W;
  localparam int SW = sstf_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  sstf_pkg::trk_t    head_r, head_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [SW-1:0]     served_r, served_nxt;
  logic [AW-1:0]     iss_idx_r, iss_idx_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  sstf_pkg::trk_t    best_gap_r, best_gap_nxt;
  sstf_pkg::trk_t    best_trk_r, best_trk_nxt;
  logic              hit_r, hit_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [79:0]       out_data_r, out_data_nxt;
  logic              out_found_r, out_found_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, last_idx;
  sstf_pkg::trk_t    ram_wdata, ram_rdata;
  sstf_pkg::gap_res_t gres;
  logic [TW:0]       sum;
  logic              in_acc, emit_go;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

  assign in_acc   = in_tvalid && in_tready;
  assign last_idx = AW'(count_r - 1'b1);
  assign emit_go  = !out_vld_r || out_tready;

  sstf_ram #(.WIDTH(sstf_pkg::TRK_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sstf_gap_unit u_gap (
    .trk      (ram_rdata),
    .head     (head_r),
    .best_gap (best_gap_r),
    .first    (cmp_idx_r == '0),
    .res      (gres)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    served_nxt    = served_r;
    iss_idx_nxt   = iss_idx_r;
    iss_done_nxt  = iss_done_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_idx_nxt  = best_idx_r;
    best_gap_nxt  = best_gap_r;
    best_trk_nxt  = best_trk_r;
    hit_nxt       = hit_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(count_r);
    ram_wdata     = in_tdata;
    ram_raddr     = '0;
    sum           = {1'b0, total_r} + (TW+1)'(best_gap_r);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == sstf_pkg::OP_PUSH) begin
            if (count_r < CW'(QUEUE_DEPTH)) begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            hit_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            iss_idx_nxt  = '0;
            iss_done_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = iss_idx_r;
        if (!iss_done_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_idx_r;
          if (iss_idx_r == last_idx) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_idx_nxt = iss_idx_r + 1'b1;
          end
        end
        if (cmp_vld_r) begin
          if (gres.take) begin
            best_idx_nxt = cmp_idx_r;
            best_gap_nxt = gres.gap;
            best_trk_nxt = ram_rdata;
          end
          if (cmp_idx_r == last_idx) begin
            hit_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        ram_raddr = last_idx;
        if (emit_go) begin
          out_vld_nxt   = 1'b1;
          out_found_nxt = hit_r;
          state_nxt     = S_IDLE;
          if (hit_r) begin
            ram_we     = 1'b1;
            ram_waddr  = best_idx_r;
            ram_wdata  = ram_rdata;
            count_nxt  = count_r - 1'b1;
            head_nxt   = best_trk_r;
            total_nxt  = sum[TW] ? '1 : sum[TW-1:0];
            served_nxt = (served_r == '1) ? served_r : served_r + 1'b1;
            out_data_nxt = {served_nxt, total_nxt, best_gap_r, best_trk_r};
          end else begin
            out_data_nxt = {served_r, total_r, sstf_pkg::trk_t'(0), head_r};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid && cfg_ready) begin
      head_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      total_r     <= '0;
      served_r    <= '0;
      iss_done_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_vld_r   <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      served_r    <= served_nxt;
      iss_done_r  <= iss_done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      out_vld_r   <= out_vld_nxt;
      out_found_r <= out_found_nxt;
    end
    iss_idx_r  <= iss_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_gap_r <= best_gap_nxt;
    best_trk_r <= best_trk_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
